@@ design/video_frame_unit_converter_unit_assert.svh @@
// Assertion macros for the raw video unit converter.
// Used by vfuc_div; empty when SYNTHESIS is defined.
`ifndef VIDEO_FRAME_UNIT_CONVERTER_UNIT_ASSERT_SVH
`define VIDEO_FRAME_UNIT_CONVERTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define VFUC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vfuc assertion failed");
`define VFUC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vfuc assertion failed");
`else
`define VFUC_ASSERT_IMP(lbl, ante, cons)
`define VFUC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/vfuc_pkg.sv @@
// Shared types and constants of the raw video unit converter.
// No dependencies.
package vfuc_pkg;

    localparam int SW = 31;
    localparam int FW = 47;
    localparam int DW = 46;
    localparam int AW = 64;

    localparam logic [1:0] U_BYTES  = 2'd0;
    localparam logic [1:0] U_FRAMES = 2'd1;
    localparam logic [1:0] U_TIME   = 2'd2;

    localparam logic [2:0] FMT_I420 = 3'd0;
    localparam logic [2:0] FMT_YV12 = 3'd1;
    localparam logic [2:0] FMT_YUY2 = 3'd2;
    localparam logic [2:0] FMT_UYVY = 3'd3;
    localparam logic [2:0] FMT_AYUV = 3'd4;
    localparam logic [2:0] FMT_RGBX = 3'd5;
    localparam logic [2:0] FMT_BGRX = 3'd6;
    localparam logic [2:0] FMT_UNKNOWN = 3'd7;

    localparam logic [2:0] REG_FMT    = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_NUM    = 3'd3;
    localparam logic [2:0] REG_DEN    = 3'd4;

    localparam logic [29:0] NS_PER_S = 30'd1000000000;
    localparam logic [AW-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {K_PASS, K_BAD, K_MUL} kind_t;

    typedef struct packed {
        logic [15:0]   num;
        logic [15:0]   den;
        logic [SW-1:0] size;
        logic [FW-1:0] fs;
        logic [DW-1:0] gd;
    } vfuc_cfg_t;

    typedef struct packed {
        kind_t         kind;
        logic [DW-1:0] d;
        logic [DW-1:0] hi;
        logic [AW-1:0] lq;
    } prod_t;

endpackage

@@ design/video_frame_unit_converter_unit.sv @@
// Top level of the raw video unit converter.
// Depends on vfuc_pkg, vfuc_cfg, vfuc_front and vfuc_div.
//
// Usage:
// Registers are written on the cfg_ channel (cfg_index, cfg_data), which is
// always ready; writes are meant to happen while no request is in flight.
// A request on the s_ channel carries the units in s_tuser and the amount in
// s_tdata; its result leaves on the m_ channel with the converted value in
// m_tdata and the ok flag in m_tuser.
// The datapath is a fixed pipeline of 70 registers: input register, case
// decode, partial products, product sum, divisor compare, 64 restoring
// divider stages with one quotient bit each, and the output register.
// One request is accepted every cycle while the output is not stalled.
// Each stage holds its item while the next stage is full and stalled, so a
// receiver that holds m_tready low fills the pipeline, after which
// s_tready falls; nothing is lost or repeated.
// Reset clears every stage valid bit and returns the configuration registers to
// their reset values; the pipeline is ready in the first cycle after reset.
module video_frame_unit_converter_unit import vfuc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // amount[63:0]
    input  logic [3:0]  s_tuser,   // from_unit[1:0], to_unit[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // converted[63:0]
    output logic [0:0]  m_tuser    // ok[0]
);

    vfuc_cfg_t cfg;
    logic      mid_valid, mid_ready;
    prod_t     mid_data;
    logic      ok;

    assign cfg_ready = 1'b1;

    vfuc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vfuc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .from_unit (s_tuser[1:0]),
        .to_unit   (s_tuser[3:2]),
        .amount    (s_tdata),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    vfuc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .converted (m_tdata),
        .ok        (ok)
    );

    assign m_tuser = ok;

endmodule

@@ design/vfuc_cfg.sv @@
// Configuration registers and derived frame size, rate products.
// Depends on vfuc_pkg.
module vfuc_cfg import vfuc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output vfuc_cfg_t   cfg
);

    logic [2:0]    fmt_reg;
    logic [13:0]   w_reg, h_reg;
    logic [15:0]   num_reg, den_reg;
    logic [SW-1:0] size_reg, size_next;
    logic [FW-1:0] fs_reg;
    logic [DW-1:0] gd_reg;

    logic [14:0] w4, h2, w2, wc4, w2x;
    logic [13:0] wh, hh;
    logic [15:0] yw;
    logic [29:0] t1, yuy, rgb;
    logic [28:0] t2;

    always_comb begin
        w4  = ({1'b0, w_reg} + 15'd3) & ~15'd3;
        h2  = ({1'b0, h_reg} + 15'd1) & ~15'd1;
        w2  = ({1'b0, w_reg} + 15'd1) & ~15'd1;
        wh  = w2[14:1];
        hh  = h2[14:1];
        wc4 = ({1'b0, wh} + 15'd3) & ~15'd3;
        w2x = {w_reg, 1'b0};
        yw  = ({1'b0, w2x} + 16'd3) & ~16'd3;
        t1  = 30'(w4) * 30'(h2);
        t2  = 29'(wc4) * 29'(hh);
        yuy = 30'(yw) * 30'(h_reg);
        rgb = 30'(w_reg) * 30'(h_reg);
        case (fmt_reg)
            FMT_I420, FMT_YV12: size_next = SW'(t1) + {1'b0, t2, 1'b0};
            FMT_YUY2, FMT_UYVY: size_next = SW'(yuy);
            FMT_AYUV, FMT_RGBX, FMT_BGRX: size_next = SW'({rgb[28:0], 2'b00});
            default: size_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg  <= FMT_UNKNOWN;
            w_reg    <= '0;
            h_reg    <= '0;
            num_reg  <= '0;
            den_reg  <= 16'd1;
            size_reg <= '0;
            fs_reg   <= '0;
            gd_reg   <= DW'(NS_PER_S);
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_FMT:    fmt_reg <= cfg_data[2:0];
                    REG_WIDTH:  w_reg   <= cfg_data[13:0];
                    REG_HEIGHT: h_reg   <= cfg_data[13:0];
                    REG_NUM:    num_reg <= cfg_data;
                    REG_DEN:    den_reg <= cfg_data;
                    default: ;
                endcase
            end
            size_reg <= size_next;
            fs_reg   <= FW'(num_reg) * FW'(size_reg);
            gd_reg   <= DW'(den_reg) * DW'(NS_PER_S);
        end
    end

    assign cfg.num  = num_reg;
    assign cfg.den  = den_reg;
    assign cfg.size = size_reg;
    assign cfg.fs   = fs_reg;
    assign cfg.gd   = gd_reg;

endmodule

@@ design/vfuc_front.sv @@
// Front pipeline: input register, case decode, partial products, product sum.
// Depends on vfuc_pkg.
module vfuc_front import vfuc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  vfuc_cfg_t     cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    from_unit,
    input  logic [1:0]    to_unit,
    input  logic [AW-1:0] amount,
    output logic          out_valid,
    input  logic          out_ready,
    output prod_t         out_data
);

    logic          v0_reg, v1_reg, v2_reg, v3_reg;
    logic          r0, r1, r2, r3;
    logic [1:0]    from_reg, to_reg;
    logic [AW-1:0] amt0_reg;

    kind_t         k1_reg, k1_next;
    logic [AW-1:0] amt1_reg, amt1_next;
    logic [DW-1:0] b1_reg, b1_next, d1_reg, d1_next;

    kind_t         k2_reg;
    logic [AW-1:0] amt2_reg;
    logic [DW-1:0] d2_reg;
    logic [54:0]   pp0_reg, pp1_reg, pp2_reg, pp3_reg;

    prod_t         p3_reg;
    logic [109:0]  prod;
    logic          fs_small;

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign r0 = !v0_reg || r1;
    assign in_ready = r0;

    always_comb begin
        fs_small  = (cfg.fs[FW-1:31] == '0);
        k1_next   = K_MUL;
        amt1_next = amt0_reg;
        b1_next   = '0;
        d1_next   = DW'(1);
        if (from_reg == to_reg || amt0_reg == '1) begin
            k1_next = K_PASS;
        end else if (from_reg == U_BYTES && to_reg == U_FRAMES) begin
            b1_next = DW'(1);
            d1_next = DW'(cfg.size);
            if (cfg.size == '0) k1_next = K_PASS;
        end else if (from_reg == U_FRAMES && to_reg == U_BYTES) begin
            b1_next = DW'(cfg.size);
        end else if (from_reg == U_TIME && to_reg == U_FRAMES) begin
            b1_next = DW'(cfg.num);
            d1_next = cfg.gd;
            if (cfg.den == '0) k1_next = K_PASS;
        end else if (from_reg == U_FRAMES && to_reg == U_TIME) begin
            b1_next = cfg.gd;
            d1_next = DW'(cfg.num);
            if (cfg.num == '0) k1_next = K_PASS;
        end else if (from_reg == U_TIME && to_reg == U_BYTES) begin
            b1_next = DW'(cfg.fs[30:0]);
            d1_next = cfg.gd;
            if (cfg.den == '0 || !fs_small) k1_next = K_PASS;
        end else if (from_reg == U_BYTES && to_reg == U_TIME) begin
            b1_next = cfg.gd;
            d1_next = DW'(cfg.fs[30:0]);
            if (cfg.fs == '0 || !fs_small) k1_next = K_PASS;
        end else begin
            k1_next = K_BAD;
        end
        if (k1_next != K_MUL && !(from_reg == to_reg || amt0_reg == '1)) begin
            amt1_next = '0;
        end
    end

    always_comb begin
        prod = 110'(pp0_reg) + (110'(pp1_reg) << 23) + (110'(pp2_reg) << 32)
             + (110'(pp3_reg) << 55);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r0) v0_reg <= in_valid;
            if (r1) v1_reg <= v0_reg;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
        if (r0) begin
            from_reg <= from_unit;
            to_reg   <= to_unit;
            amt0_reg <= amount;
        end
        if (r1) begin
            k1_reg   <= k1_next;
            amt1_reg <= amt1_next;
            b1_reg   <= b1_next;
            d1_reg   <= d1_next;
        end
        if (r2) begin
            k2_reg   <= k1_reg;
            amt2_reg <= amt1_reg;
            d2_reg   <= d1_reg;
            pp0_reg  <= 55'(amt1_reg[31:0])  * 55'(b1_reg[22:0]);
            pp1_reg  <= 55'(amt1_reg[31:0])  * 55'(b1_reg[45:23]);
            pp2_reg  <= 55'(amt1_reg[63:32]) * 55'(b1_reg[22:0]);
            pp3_reg  <= 55'(amt1_reg[63:32]) * 55'(b1_reg[45:23]);
        end
        if (r3) begin
            p3_reg.kind <= k2_reg;
            p3_reg.d    <= d2_reg;
            p3_reg.hi   <= prod[109:64];
            p3_reg.lq   <= (k2_reg == K_MUL) ? prod[63:0] : amt2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = p3_reg;

endmodule

@@ design/vfuc_div.sv @@
// Divider pipeline, one quotient bit per stage, then saturation and output register.
// Depends on vfuc_pkg and the assertion macro header.
`include "video_frame_unit_converter_unit_assert.svh"
module vfuc_div import vfuc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  prod_t         in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [AW-1:0] converted,
    output logic          ok
);

    localparam int NS = AW;

    typedef struct packed {
        kind_t         kind;
        logic          sat;
        logic [DW-1:0] r;
        logic [DW-1:0] d;
        logic [AW-1:0] lq;
    } div_t;

    div_t          st_reg [0:NS];
    logic          v_reg  [0:NS];
    logic          rdy    [0:NS+1];
    logic          ov_reg;
    logic [AW-1:0] conv_reg;
    logic          ok_reg;

    assign rdy[NS+1] = !ov_reg || out_ready;
    assign in_ready  = rdy[0];

    genvar i;
    generate
        for (i = 0; i <= NS; i++) begin : g_rdy
            assign rdy[i] = !v_reg[i] || rdy[i+1];
        end
        for (i = 1; i <= NS; i++) begin : g_stage
            logic [DW:0]   rs;
            logic          ge;
            div_t          st_next;
            always_comb begin
                rs = {st_reg[i-1].r, st_reg[i-1].lq[AW-1]};
                ge = (rs >= {1'b0, st_reg[i-1].d});
                st_next = st_reg[i-1];
                if (st_reg[i-1].kind == K_MUL) begin
                    st_next.r  = ge ? DW'(rs - {1'b0, st_reg[i-1].d}) : DW'(rs);
                    st_next.lq = {st_reg[i-1].lq[AW-2:0], ge};
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
                if (rdy[i]) begin
                    st_reg[i] <= st_next;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[NS+1]) ov_reg <= v_reg[NS];
        end
        if (rdy[0]) begin
            st_reg[0].kind <= in_data.kind;
            st_reg[0].sat  <= (in_data.hi >= in_data.d);
            st_reg[0].r    <= in_data.hi;
            st_reg[0].d    <= in_data.d;
            st_reg[0].lq   <= in_data.lq;
        end
        if (rdy[NS+1]) begin
            ok_reg <= (st_reg[NS].kind != K_BAD);
            if (st_reg[NS].kind == K_MUL && (st_reg[NS].sat || st_reg[NS].lq[AW-1])) begin
                conv_reg <= POS_MAX;
            end else begin
                conv_reg <= st_reg[NS].lq;
            end
        end
    end

    assign out_valid = ov_reg;
    assign converted = conv_reg;
    assign ok        = ok_reg;

    `VFUC_ASSERT_NEXT(a_out_hold, ov_reg && !out_ready, ov_reg && $stable(conv_reg))
    `VFUC_ASSERT_IMP(a_bad_zero, ov_reg && !ok_reg, conv_reg == '0)
    `VFUC_ASSERT_IMP(a_bad_entry, v_reg[0] && st_reg[0].kind == K_BAD, st_reg[0].lq == '0)

endmodule
